FILE: hw/rtl/tfz_pkg.sv
package tfz_pkg;

  // Default grade precision (fraction bits, 1.0 = 2**bits)
  localparam int GRADE_FRAC_BITS_DEF = 15;

  // Field widths
  localparam int HR_W   = 8;
  localparam int BT_W   = 9;
  localparam int HS_W   = 15;
  localparam int RULE_W = 9;

  // Slope distances never exceed the widest span (96)
  localparam int DIST_W = 7;

  // Score fraction bits (Q7.8)
  localparam int SCORE_FRAC = 8;

  localparam logic [RULE_W-1:0] RULE_MAP_RST = 9'd146;
  localparam logic [HS_W-1:0]   SCORE_MAX    = 15'd25600;

  // Extra bits kept by the reciprocal estimate of each slope
  localparam int RECIP_SHIFT = 8;

  localparam int NUM_SLOPES = 8;
  localparam int NUM_GRADES = 6;
  localparam int NUM_RULES  = 9;
  localparam int NUM_CLASS  = 3;

  // Register stages in front of the divider
  localparam int PRE_STAGES = 8;

  // Slope spans: heart falling/rising/upper falling/high rising,
  // temp falling/rising/upper falling/high rising
  localparam int SPAN [NUM_SLOPES] = '{36, 36, 22, 96, 65, 65, 25, 10};

  // Which slope each grade takes for shape GS_SLOPE_A and for GS_SLOPE_B
  // (grades 0..2 heart, 3..5 temperature)
  localparam int SLOPE_A [NUM_GRADES] = '{0, 1, 3, 4, 5, 7};
  localparam int SLOPE_B [NUM_GRADES] = '{0, 2, 3, 4, 6, 7};

  // Heart rate breakpoints (beats per minute)
  localparam logic [HR_W-1:0] HR_BP_LO  = 8'd60;
  localparam logic [HR_W-1:0] HR_BP_MID = 8'd96;
  localparam logic [HR_W-1:0] HR_BP_TOP = 8'd170;
  localparam logic [HR_W-1:0] HR_BP_HI  = 8'd192;

  // Temperature breakpoints (0.1 degree)
  localparam logic [BT_W-1:0] BT_BP_LO   = 9'd300;
  localparam logic [BT_W-1:0] BT_BP_NORM = 9'd365;
  localparam logic [BT_W-1:0] BT_BP_TOP  = 9'd375;
  localparam logic [BT_W-1:0] BT_BP_HI   = 9'd400;

  // Rule output levels
  localparam int Z_LOW            = 25;
  localparam int Z_HIGH           = 90;
  localparam int Z_HEALTHY_BASE   = 50;
  localparam int Z_UNHEALTHY_BASE = 80;
  localparam int Z_GAIN           = 30;

  // Grade shape selector
  typedef enum logic [1:0] {
    GS_ZERO,
    GS_FULL,
    GS_SLOPE_A,
    GS_SLOPE_B
  } grade_sel_t;

endpackage

FILE: hw/rtl/tsukamoto_fuzzy_two_input.sv
// Two-input fuzzy health scorer (nine rules, weighted-average defuzzing).
//
// Input channel: in_valid/in_ready carry one beat of heart rate (bpm) and
// body temperature (0.1 degree). Result channel: out_valid/out_ready carry
// one beat of health_score in Q7.8 per input beat, in input order.
// Config channel: cfg_valid/cfg_ready write the 9-bit rule map; cfg_ready
// is always high. Write it only while the pipeline is empty.
//
// Pipeline: 8 + 15 = 23 register stages. Eight stages grade, take rule
// minima, weight and sum; the last 15 stages are a restoring divider
// producing one quotient bit per stage.
// Throughput: one beat per cycle while out_ready is high or a stage has
// a hole; otherwise the input stalls as described below.
//
// Reset clears all stage valid bits and loads the rule map with 146.
// When the receiver stalls, the output beat holds and earlier stages keep
// moving until they close up behind it; in_ready drops only when every
// stage holds a beat and out_ready is low.
module tsukamoto_fuzzy_two_input #(
  parameter int GRADE_FRAC_BITS = tfz_pkg::GRADE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tfz_pkg::HR_W-1:0]    in_heart_rate,
  input  logic [tfz_pkg::BT_W-1:0]    in_body_temp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tfz_pkg::HS_W-1:0]    out_health_score,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tfz_pkg::RULE_W-1:0]  cfg_rule_map
);

  localparam int F      = GRADE_FRAC_BITS;
  localparam int GW     = F + 1;                 // grade, 0..1.0
  localparam int ZW     = F + 7;                 // rule output, < 128.0
  localparam int PW     = GW + ZW;               // weighted product
  localparam int PSUM_W = PW + 2;                // sum of three products
  localparam int NUM_W  = PW + 4;                // sum of nine products
  localparam int DPS_W  = GW + 2;
  localparam int DEN_W  = GW + 4;
  localparam int RS     = F + tfz_pkg::RECIP_SHIFT;
  localparam int PROD_W = tfz_pkg::DIST_W + RS;
  localparam int CW     = tfz_pkg::DIST_W + F + 1;
  localparam int QW     = tfz_pkg::HS_W;
  localparam int NS     = tfz_pkg::PRE_STAGES + QW;
  localparam int NSL    = tfz_pkg::NUM_SLOPES;
  localparam int NG     = tfz_pkg::NUM_GRADES;
  localparam int NR     = tfz_pkg::NUM_RULES;
  localparam int NC     = tfz_pkg::NUM_CLASS;
  localparam int DW     = tfz_pkg::DIST_W;

  localparam logic [GW-1:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [ZW-1:0] Z_LO_V  = ZW'(tfz_pkg::Z_LOW) << F;
  localparam logic [ZW-1:0] Z_HI_V  = ZW'(tfz_pkg::Z_HIGH) << F;
  localparam logic [ZW-1:0] Z_HB_V  = ZW'(tfz_pkg::Z_HEALTHY_BASE) << F;
  localparam logic [ZW-1:0] Z_UB_V  = ZW'(tfz_pkg::Z_UNHEALTHY_BASE) << F;

  // ---------------------------------------------------------------
  // Rule map register
  // ---------------------------------------------------------------
  logic [tfz_pkg::RULE_W-1:0] rule_map_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_map_r <= tfz_pkg::RULE_MAP_RST;
    end else if (cfg_valid) begin
      rule_map_r <= cfg_rule_map;
    end
  end

  // ---------------------------------------------------------------
  // Stage valids and enables; a stage moves when it or any later stage
  // has a hole or the output beat is taken
  // ---------------------------------------------------------------
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS-1:0] en;

  assign v_in = {v_r[NS-2:0], in_valid};

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_ready || !(&v_r[NS-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  // ---------------------------------------------------------------
  // Stage A: slope distances and grade shapes
  // ---------------------------------------------------------------
  logic [DW-1:0]       dist_nxt  [NSL];
  tfz_pkg::grade_sel_t sel_nxt   [NG];
  logic [DW-1:0]       dist_a_r  [NSL];
  tfz_pkg::grade_sel_t sel_a_r   [NG];

  always_comb begin
    logic [tfz_pkg::HR_W-1:0] x;
    logic [tfz_pkg::BT_W-1:0] t;
    x = in_heart_rate;
    t = in_body_temp;

    dist_nxt[0] = (x inside {[tfz_pkg::HR_BP_LO + 8'd1 : tfz_pkg::HR_BP_MID]}) ?
                  DW'(tfz_pkg::HR_BP_MID - x) : '0;
    dist_nxt[1] = (x inside {[tfz_pkg::HR_BP_LO : tfz_pkg::HR_BP_MID - 8'd1]}) ?
                  DW'(x - tfz_pkg::HR_BP_LO) : '0;
    dist_nxt[2] = (x inside {[tfz_pkg::HR_BP_TOP + 8'd1 : tfz_pkg::HR_BP_HI]}) ?
                  DW'(tfz_pkg::HR_BP_HI - x) : '0;
    dist_nxt[3] = (x inside {[tfz_pkg::HR_BP_MID + 8'd1 : tfz_pkg::HR_BP_HI]}) ?
                  DW'(x - tfz_pkg::HR_BP_MID) : '0;
    dist_nxt[4] = (t inside {[tfz_pkg::BT_BP_LO + 9'd1 : tfz_pkg::BT_BP_NORM]}) ?
                  DW'(tfz_pkg::BT_BP_NORM - t) : '0;
    dist_nxt[5] = (t inside {[tfz_pkg::BT_BP_LO + 9'd1 : tfz_pkg::BT_BP_NORM - 9'd1]}) ?
                  DW'(t - tfz_pkg::BT_BP_LO) : '0;
    dist_nxt[6] = (t inside {[tfz_pkg::BT_BP_TOP + 9'd1 : tfz_pkg::BT_BP_HI]}) ?
                  DW'(tfz_pkg::BT_BP_HI - t) : '0;
    dist_nxt[7] = (t inside {[tfz_pkg::BT_BP_NORM : tfz_pkg::BT_BP_TOP]}) ?
                  DW'(t - tfz_pkg::BT_BP_NORM) : '0;

    // heart: below normal, normal, above normal
    if (x <= tfz_pkg::HR_BP_LO)       sel_nxt[0] = tfz_pkg::GS_FULL;
    else if (x <= tfz_pkg::HR_BP_MID) sel_nxt[0] = tfz_pkg::GS_SLOPE_A;
    else                              sel_nxt[0] = tfz_pkg::GS_ZERO;

    if (x < tfz_pkg::HR_BP_LO || x > tfz_pkg::HR_BP_HI) sel_nxt[1] = tfz_pkg::GS_ZERO;
    else if (x < tfz_pkg::HR_BP_MID)                    sel_nxt[1] = tfz_pkg::GS_SLOPE_A;
    else if (x <= tfz_pkg::HR_BP_TOP)                   sel_nxt[1] = tfz_pkg::GS_FULL;
    else                                                sel_nxt[1] = tfz_pkg::GS_SLOPE_B;

    if (x <= tfz_pkg::HR_BP_MID)      sel_nxt[2] = tfz_pkg::GS_ZERO;
    else if (x <= tfz_pkg::HR_BP_HI)  sel_nxt[2] = tfz_pkg::GS_SLOPE_A;
    else                              sel_nxt[2] = tfz_pkg::GS_FULL;

    // temperature: low, normal, high (high stays 1.0 above 37.5)
    if (t <= tfz_pkg::BT_BP_LO)        sel_nxt[3] = tfz_pkg::GS_FULL;
    else if (t <= tfz_pkg::BT_BP_NORM) sel_nxt[3] = tfz_pkg::GS_SLOPE_A;
    else                               sel_nxt[3] = tfz_pkg::GS_ZERO;

    if (t <= tfz_pkg::BT_BP_LO || t > tfz_pkg::BT_BP_HI) sel_nxt[4] = tfz_pkg::GS_ZERO;
    else if (t < tfz_pkg::BT_BP_NORM)                    sel_nxt[4] = tfz_pkg::GS_SLOPE_A;
    else if (t <= tfz_pkg::BT_BP_TOP)                    sel_nxt[4] = tfz_pkg::GS_FULL;
    else                                                 sel_nxt[4] = tfz_pkg::GS_SLOPE_B;

    if (t < tfz_pkg::BT_BP_NORM)       sel_nxt[5] = tfz_pkg::GS_ZERO;
    else if (t <= tfz_pkg::BT_BP_TOP)  sel_nxt[5] = tfz_pkg::GS_SLOPE_A;
    else                               sel_nxt[5] = tfz_pkg::GS_FULL;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dist_a_r <= dist_nxt;
      sel_a_r  <= sel_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage B: quotient estimate by reciprocal multiply
  // ---------------------------------------------------------------
  logic [GW-1:0]       q0_nxt   [NSL];
  logic [GW-1:0]       q0_b_r   [NSL];
  logic [DW-1:0]       dist_b_r [NSL];
  tfz_pkg::grade_sel_t sel_b_r  [NG];

  for (genvar i = 0; i < NSL; i++) begin : g_recip
    localparam logic [RS-1:0] RCP =
      RS'((64'd1 << RS) / 64'(tfz_pkg::SPAN[i]));
    logic [PROD_W-1:0] est;
    assign est       = PROD_W'(dist_a_r[i]) * PROD_W'(RCP);
    assign q0_nxt[i] = GW'(est >> tfz_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q0_b_r   <= q0_nxt;
      dist_b_r <= dist_a_r;
      sel_b_r  <= sel_a_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage C: correct estimate by one, then pick each grade
  // ---------------------------------------------------------------
  logic [GW-1:0] qfix      [NSL];
  logic [GW-1:0] grade_nxt [NG];
  logic [GW-1:0] grade_c_r [NG];

  for (genvar i = 0; i < NSL; i++) begin : g_fix
    logic [CW-1:0] dividend;
    logic [CW-1:0] back;
    logic [CW-1:0] rmd;
    assign dividend = CW'(dist_b_r[i]) << F;
    assign back     = CW'(q0_b_r[i]) * CW'(tfz_pkg::SPAN[i]);
    assign rmd      = dividend - back;
    assign qfix[i]  = (rmd >= CW'(tfz_pkg::SPAN[i])) ? q0_b_r[i] + GW'(1) : q0_b_r[i];
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      case (sel_b_r[g])
        tfz_pkg::GS_ZERO:    grade_nxt[g] = '0;
        tfz_pkg::GS_FULL:    grade_nxt[g] = ONE;
        tfz_pkg::GS_SLOPE_A: grade_nxt[g] = qfix[tfz_pkg::SLOPE_A[g]];
        tfz_pkg::GS_SLOPE_B: grade_nxt[g] = qfix[tfz_pkg::SLOPE_B[g]];
        default:             grade_nxt[g] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      grade_c_r <= grade_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage D: rule strengths, min of heart and temperature grades
  // ---------------------------------------------------------------
  logic [GW-1:0] str_nxt [NR];
  logic [GW-1:0] str_d_r [NR];

  always_comb begin
    for (int h = 0; h < NC; h++) begin
      for (int t = 0; t < NC; t++) begin
        str_nxt[h*NC+t] = (grade_c_r[h] < grade_c_r[NC+t]) ?
                          grade_c_r[h] : grade_c_r[NC+t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      str_d_r <= str_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage E: crisp rule outputs
  // ---------------------------------------------------------------
  logic [ZW-1:0] z_nxt   [NR];
  logic [ZW-1:0] z_e_r   [NR];
  logic [GW-1:0] str_e_r [NR];

  always_comb begin
    for (int k = 0; k < NR; k++) begin
      logic [ZW-1:0] gain;
      gain = ZW'(tfz_pkg::Z_GAIN) * ZW'(str_d_r[k]);
      if (rule_map_r[k]) begin
        if (str_d_r[k] == '0)      z_nxt[k] = Z_LO_V;
        else if (str_d_r[k] >= ONE) z_nxt[k] = Z_HI_V;
        else                        z_nxt[k] = Z_HB_V + gain;
      end else begin
        if (str_d_r[k] >= ONE)      z_nxt[k] = Z_LO_V;
        else if (str_d_r[k] == '0) z_nxt[k] = Z_HI_V;
        else                        z_nxt[k] = Z_UB_V - gain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      z_e_r   <= z_nxt;
      str_e_r <= str_d_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage F: strength-weighted outputs
  // ---------------------------------------------------------------
  logic [PW-1:0] prod_nxt [NR];
  logic [PW-1:0] prod_f_r [NR];
  logic [GW-1:0] str_f_r  [NR];

  always_comb begin
    for (int k = 0; k < NR; k++) begin
      prod_nxt[k] = PW'(str_e_r[k]) * PW'(z_e_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      prod_f_r <= prod_nxt;
      str_f_r  <= str_e_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage G: partial sums in groups of three
  // ---------------------------------------------------------------
  logic [PSUM_W-1:0] psum_nxt [NC];
  logic [DPS_W-1:0]  dsum_nxt [NC];
  logic [PSUM_W-1:0] psum_g_r [NC];
  logic [DPS_W-1:0]  dsum_g_r [NC];

  always_comb begin
    for (int j = 0; j < NC; j++) begin
      psum_nxt[j] = PSUM_W'(prod_f_r[j*NC]) + PSUM_W'(prod_f_r[j*NC+1]) +
                    PSUM_W'(prod_f_r[j*NC+2]);
      dsum_nxt[j] = DPS_W'(str_f_r[j*NC]) + DPS_W'(str_f_r[j*NC+1]) +
                    DPS_W'(str_f_r[j*NC+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      psum_g_r <= psum_nxt;
      dsum_g_r <= dsum_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage H: numerator and denominator totals
  // ---------------------------------------------------------------
  logic [NUM_W-1:0] num_h_r;
  logic [DEN_W-1:0] den_h_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      num_h_r <= NUM_W'(psum_g_r[0]) + NUM_W'(psum_g_r[1]) + NUM_W'(psum_g_r[2]);
      den_h_r <= DEN_W'(dsum_g_r[0]) + DEN_W'(dsum_g_r[1]) + DEN_W'(dsum_g_r[2]);
    end
  end

  // ---------------------------------------------------------------
  // Divider: one quotient bit per stage, MSB first
  // ---------------------------------------------------------------
  logic [NUM_W-1:0] rem_r  [QW];
  logic [NUM_W-1:0] dvs_r  [QW];
  logic [QW-1:0]    quo_r  [QW];
  logic             zero_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] dvs_in;
    logic [QW-1:0]    quo_in;
    logic             zero_in;
    logic [NUM_W-1:0] trial;
    logic             ge;
    logic [QW-1:0]    quo_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = num_h_r;
      assign dvs_in  = NUM_W'(den_h_r) << (F - tfz_pkg::SCORE_FRAC);
      assign quo_in  = '0;
      assign zero_in = (den_h_r == '0);
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign dvs_in  = dvs_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign zero_in = zero_r[j-1];
    end

    assign trial = dvs_in << SH;
    assign ge    = (rem_in >= trial);

    always_comb begin
      quo_nxt     = quo_in;
      quo_nxt[SH] = ge;
      // empty rule set scores zero
      if (j == QW - 1 && zero_in) begin
        quo_nxt = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en[tfz_pkg::PRE_STAGES + j]) begin
        rem_r[j]  <= ge ? rem_in - trial : rem_in;
        dvs_r[j]  <= dvs_in;
        quo_r[j]  <= quo_nxt;
        zero_r[j] <= zero_in;
      end
    end
  end

  assign out_health_score = quo_r[QW-1];

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------

  // some rule always fires, so the strength sum never reaches the output as zero
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] |-> !zero_r[QW-1])
    else $error("zero strength sum at output");

  // weighted average stays within the 0..100 score range
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] |-> (out_health_score <= tfz_pkg::SCORE_MAX))
    else $error("health score out of range");

  // beats in flight change only by beats accepted and delivered
  a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(v_r) == $countones($past(v_r)) + int'($past(in_valid && in_ready))
                          - int'($past(out_valid && out_ready))))
    else $error("pipeline lost or duplicated a beat");

endmodule
